>>> rtl/asdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdm_pkg
// Shared types and constants of the ADC scan deadband mapper.
// ----------------------------------------------------------------------------
package asdm_pkg;

  localparam int CHANNELS_DEF  = 6;
  localparam int VAR_COUNT_DEF = 128;

  localparam int CH_W     = 3;
  localparam int SMP_W    = 10;
  localparam int MAP_W    = 48;
  localparam int MAP_REGS = 6;
  localparam int VAL_W    = 16;
  localparam int PROD_W   = 26;   // 10 x 16 bit magnitude product
  localparam int REG_IDX_W = 3;

  localparam logic [10:0] DIV_K    = 11'd1023;
  localparam logic [7:0]  MAP_NONE = 8'hFF;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_JITTER = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAP0   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAP5   = 3'd7;

  // request types
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_DONE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef struct packed {
    logic             req_type;
    logic [SMP_W-1:0] sample;
  } req_t;

  typedef struct packed {
    logic             start_conv;
    logic [CH_W-1:0]  conv_channel;
    logic             raw_valid;
    logic [CH_W-1:0]  raw_channel;
    logic [SMP_W-1:0] raw_value;
    logic             map_valid;
    logic [7:0]       map_target;
    logic [7:0]       map_index;
    logic [VAL_W-1:0] mapped_value;
  } res_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] index;
    logic [MAP_W-1:0]     value;
  } cfg_wr_t;

  typedef struct packed {
    logic [MAP_REGS-1:0]             enable_mask;
    logic [SMP_W-1:0]                jitter_threshold;
    logic [MAP_REGS-1:0][MAP_W-1:0]  map_ch;
  } cfg_regs_t;

  // scan stage to divide stage: result with the map still to be scaled
  typedef struct packed {
    res_t              res;
    logic              neg;
    logic [PROD_W-1:0] prod;
    logic [VAL_W-1:0]  lo;
  } mid_t;

endpackage

>>> rtl/asdm_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdm_chan_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface asdm_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/asdm_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdm_scan
// Input register, scan state, deadband filter and map product.
// ----------------------------------------------------------------------------
module asdm_scan #(
  parameter int CHANNELS  = asdm_pkg::CHANNELS_DEF,
  parameter int VAR_COUNT = asdm_pkg::VAR_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  asdm_pkg::cfg_regs_t   cfg_regs,
  asdm_chan_if.sink             req_ch,
  asdm_chan_if.source           mid_ch
);
  import asdm_pkg::*;

  localparam int LV_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);
  localparam logic [7:0]      VAR_LIM = 8'(VAR_COUNT);

  logic             in_valid;
  req_t             in_q;
  logic             mid_valid;
  mid_t             mid_q;

  phase_t           phase, phase_next;
  logic [CH_W-1:0]  channel_index, channel_next;
  logic [SMP_W-1:0] pending_sample, pending_next;
  logic [SMP_W-1:0] last_values [CHANNELS];

  logic             fire;
  logic             has_result;
  logic             keep;
  logic             start;
  logic [CH_W-1:0]  nxt;
  logic [SMP_W-1:0] ov, diff;
  logic [MAP_W-1:0] mw;
  logic [7:0]       tgt;
  logic [VAL_W-1:0] lo, hi, dmag;
  logic             do_map;
  mid_t             mid_next;

  assign ov   = last_values[channel_index[LV_W-1:0]];
  assign diff = (pending_sample > ov) ? pending_sample - ov : ov - pending_sample;
  assign mw   = cfg_regs.map_ch[channel_index];
  assign tgt  = mw[47:40];
  assign lo   = mw[31:16];
  assign hi   = mw[15:0];
  assign dmag = (hi < lo) ? lo - hi : hi - lo;
  assign nxt  = (channel_index == CH_LAST) ? '0 : channel_index + 1'b1;
  assign start = cfg_regs.enable_mask[nxt];

  always_comb begin
    phase_next   = phase;
    channel_next = channel_index;
    pending_next = pending_sample;
    keep         = 1'b0;
    has_result   = 1'b0;
    if (in_q.req_type == REQ_DONE) begin
      phase_next   = PH_DONE;
      pending_next = in_q.sample;
    end else begin
      case (phase)
        PH_RUN: begin
          // wait for the running conversion
        end
        PH_DONE: begin
          keep = (pending_sample != ov) &&
                 !((cfg_regs.jitter_threshold != '0) && (diff < cfg_regs.jitter_threshold));
          channel_next = nxt;
          phase_next   = start ? PH_RUN : PH_IDLE;
          has_result   = start || keep;
        end
        default: begin
          channel_next = nxt;
          phase_next   = start ? PH_RUN : PH_IDLE;
          has_result   = start;
        end
      endcase
    end
  end

  assign do_map = keep && (tgt != MAP_NONE) && (tgt < VAR_LIM);

  always_comb begin
    mid_next = '0;
    mid_next.res.start_conv   = start;
    mid_next.res.conv_channel = nxt;
    if (keep) begin
      mid_next.res.raw_valid   = 1'b1;
      mid_next.res.raw_channel = channel_index;
      mid_next.res.raw_value   = pending_sample;
    end
    if (do_map) begin
      mid_next.res.map_valid  = 1'b1;
      mid_next.res.map_target = tgt;
      mid_next.res.map_index  = mw[39:32];
      mid_next.neg  = hi < lo;
      mid_next.prod = PROD_W'(pending_sample) * PROD_W'(dmag);
      mid_next.lo   = lo;
    end
  end

  // items without a result pass through the state but never occupy the next stage
  assign fire = in_valid && (!has_result || !mid_valid || mid_ch.ready);
  assign req_ch.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req_ch.ready) begin
      in_valid <= req_ch.valid;
    end
    if (req_ch.ready && req_ch.valid) begin
      in_q <= req_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      channel_index  <= '0;
      pending_sample <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_values[i] <= '0;
      end
    end else if (fire) begin
      phase          <= phase_next;
      channel_index  <= channel_next;
      pending_sample <= pending_next;
      if (keep) begin
        last_values[channel_index[LV_W-1:0]] <= pending_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (!mid_valid || mid_ch.ready) begin
      mid_valid <= fire && has_result;
    end
    if ((!mid_valid || mid_ch.ready) && fire && has_result) begin
      mid_q <= mid_next;
    end
  end

  assign mid_ch.valid = mid_valid;
  assign mid_ch.data  = mid_q;

endmodule

>>> rtl/asdm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdm_div
// Divide the map product by 1023, apply the low end, hold the result.
// ----------------------------------------------------------------------------
module asdm_div (
  input  logic        clk,
  input  logic        rst,
  asdm_chan_if.sink   mid_ch,
  asdm_chan_if.source res_ch
);
  import asdm_pkg::*;

  logic              out_valid;
  res_t              out_q;
  res_t              res_next;
  logic [PROD_W-1:0] m;
  logic [VAL_W-1:0]  t;
  logic [16:0]       r;
  logic [6:0]        t2;
  logic [10:0]       r2;
  logic [VAL_W-1:0]  q;

  // m = 1023*t + r, r = 1023*t2 + r2, r2 below twice the divisor
  assign m  = mid_ch.data.prod;
  assign t  = m[25:10];
  assign r  = {1'b0, t} + 17'(m[9:0]);
  assign t2 = r[16:10];
  assign r2 = 11'(t2) + 11'(r[9:0]);
  assign q  = t + VAL_W'(t2) + VAL_W'(r2 >= DIV_K);

  always_comb begin
    res_next = mid_ch.data.res;
    res_next.mapped_value = mid_ch.data.neg ? mid_ch.data.lo - q : mid_ch.data.lo + q;
  end

  assign mid_ch.ready = !out_valid || res_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_ch.ready) begin
      out_valid <= mid_ch.valid;
    end
    if (mid_ch.ready && mid_ch.valid) begin
      out_q <= res_next;
    end
  end

  assign res_ch.valid = out_valid;
  assign res_ch.data  = out_q;

endmodule

>>> rtl/adc_scan_deadband_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_scan_deadband_mapper_top
// Round-robin ADC scanner with per-channel deadband and linear mapping.
// ----------------------------------------------------------------------------
// Takes one request per cycle when nothing stalls. A request passes an
// input register, then the scan stage (state update, deadband test, map
// product), then the divide stage whose register drives the result channel.
// Conversion-done requests and ticks with nothing to report update state and
// give no result.
module adc_scan_deadband_mapper_top #(
  parameter int CHANNELS  = asdm_pkg::CHANNELS_DEF,
  parameter int VAR_COUNT = asdm_pkg::VAR_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  asdm_chan_if.sink   cfg_ch,
  asdm_chan_if.sink   req_ch,
  asdm_chan_if.source res_ch
);
  import asdm_pkg::*;

  cfg_regs_t cfg_regs;
  cfg_wr_t   wr;

  asdm_chan_if #(.T(mid_t)) mid_ch ();

  assign wr = cfg_ch.data;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.enable_mask      <= '0;
      cfg_regs.jitter_threshold <= '0;
      for (int i = 0; i < MAP_REGS; i++) begin
        cfg_regs.map_ch[i] <= {MAP_NONE, 40'd0};
      end
    end else if (cfg_ch.valid) begin
      if (wr.index == REG_ENABLE) begin
        cfg_regs.enable_mask <= wr.value[MAP_REGS-1:0];
      end else if (wr.index == REG_JITTER) begin
        cfg_regs.jitter_threshold <= wr.value[SMP_W-1:0];
      end else if (wr.index inside {[REG_MAP0:REG_MAP5]}) begin
        cfg_regs.map_ch[wr.index - REG_MAP0] <= wr.value;
      end
    end
  end

  asdm_scan #(
    .CHANNELS  (CHANNELS),
    .VAR_COUNT (VAR_COUNT)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .req_ch   (req_ch),
    .mid_ch   (mid_ch.source)
  );

  asdm_div u_div (
    .clk    (clk),
    .rst    (rst),
    .mid_ch (mid_ch.sink),
    .res_ch (res_ch)
  );

endmodule

>>> sim/asdm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdm_checker
// Watches the configuration, request and result channels of the ADC scan
// deadband mapper, keeps its own copy of the scan state and registers, works
// out the result that each taken request should give, and compares every
// result taken from the block with the oldest one still waiting.
// ----------------------------------------------------------------------------
module asdm_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  asdm_pkg::cfg_wr_t cfg_data,
  input  logic              req_valid,
  input  logic              req_ready,
  input  asdm_pkg::req_t    req_data,
  input  logic              res_valid,
  input  logic              res_ready,
  input  asdm_pkg::res_t    res_data,
  output int                mismatches,
  output int                outstanding
);
  import asdm_pkg::*;

  logic [MAP_REGS-1:0] en_mask;
  logic [SMP_W-1:0]    jitter;
  logic [MAP_W-1:0]    map_word [MAP_REGS];

  phase_t              phase;
  logic [CH_W-1:0]     cur_ch;
  logic [SMP_W-1:0]    held_sample;
  logic [SMP_W-1:0]    kept_value [MAP_REGS];

  res_t                scan_results_q [$];

  function automatic string fmt_res(input res_t r);
    return $sformatf("conv=%0b/ch%0d raw=%0b/ch%0d/%0d map=%0b/t%0d/i%0d/%0d",
                     r.start_conv, r.conv_channel, r.raw_valid, r.raw_channel,
                     r.raw_value, r.map_valid, r.map_target, r.map_index,
                     r.mapped_value);
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, what);
  endtask

  // Advance the scan model by one request; queue the result it gives, if any.
  task automatic scan_step(input req_t r);
    res_t             out;
    logic [CH_W-1:0]  ch;
    logic [CH_W-1:0]  nxt;
    logic [SMP_W-1:0] nv;
    logic [SMP_W-1:0] ov;
    logic [SMP_W-1:0] diff;
    logic             keep;
    logic [7:0]       tgt;
    longint           lo;
    longint           hi;
    longint           q;
    out = '0;
    if (r.req_type == REQ_DONE) begin
      phase       = PH_DONE;
      held_sample = r.sample;
      return;
    end
    if (phase == PH_RUN) return;
    ch = (cur_ch >= CH_W'(CHANNELS_DEF)) ? '0 : cur_ch;
    if (phase == PH_DONE) begin
      nv   = held_sample;
      ov   = kept_value[ch];
      diff = (nv > ov) ? nv - ov : ov - nv;
      keep = (nv != ov) && !(jitter != '0 && diff < jitter);
      if (keep) begin
        kept_value[ch]  = nv;
        out.raw_valid   = 1'b1;
        out.raw_channel = ch;
        out.raw_value   = nv;
        tgt = map_word[ch][47:40];
        if (tgt != MAP_NONE && tgt < VAR_COUNT_DEF) begin
          lo = longint'(map_word[ch][31:16]);
          hi = longint'(map_word[ch][15:0]);
          // signed divide: truncates toward zero when the map runs downward
          q  = (longint'(nv) * (hi - lo)) / 1023;
          out.map_valid    = 1'b1;
          out.map_target   = tgt;
          out.map_index    = map_word[ch][39:32];
          out.mapped_value = VAL_W'(lo + q);
        end
      end
      phase = PH_IDLE;
    end
    nxt = (ch + 1'b1 >= CH_W'(CHANNELS_DEF)) ? '0 : ch + 1'b1;
    cur_ch = nxt;
    out.conv_channel = nxt;
    if (en_mask[nxt]) begin
      phase          = PH_RUN;
      out.start_conv = 1'b1;
    end
    if (out.start_conv || out.raw_valid) scan_results_q.push_back(out);
  endtask

  always @(posedge clk) begin
    res_t exp_res;
    if (rst) begin
      en_mask     = '0;
      jitter      = '0;
      phase       = PH_IDLE;
      cur_ch      = '0;
      held_sample = '0;
      for (int k = 0; k < MAP_REGS; k++) begin
        map_word[k]   = {MAP_NONE, 40'd0};
        kept_value[k] = '0;
      end
      scan_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_data.index == REG_ENABLE) begin
          en_mask = cfg_data.value[MAP_REGS-1:0];
        end else if (cfg_data.index == REG_JITTER) begin
          jitter = cfg_data.value[SMP_W-1:0];
        end else if (cfg_data.index inside {[REG_MAP0:REG_MAP5]}) begin
          map_word[cfg_data.index - REG_MAP0] = cfg_data.value;
        end
      end
      if (req_valid && req_ready) scan_step(req_data);
      if (res_valid && res_ready) begin
        if (scan_results_q.size() == 0) begin
          report({"result with nothing expected: got ", fmt_res(res_data)});
        end else begin
          exp_res = scan_results_q.pop_front();
          if (res_data !== exp_res)
            report({"result mismatch: exp ", fmt_res(exp_res), " got ", fmt_res(res_data)});
        end
      end
    end
    outstanding <= scan_results_q.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the ADC scan deadband mapper: a directed opening on the map
// and deadband corner cases, then phases of random conversion/tick requests
// under changing register settings, with random idling on both channels, a
// long result stall and a drained pause. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb;
  import asdm_pkg::*;

  localparam int SEQS_PER_PHASE = 170;
  localparam int QUIET_LIMIT    = 5000;
  localparam int LONG_STALL     = 400;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   idle_pct;
  int   quiet_cycles;
  bit   sink_hold_req;

  logic [MAP_REGS-1:0] cur_en;
  logic [SMP_W-1:0]    cur_jit;
  logic [MAP_W-1:0]    cur_map [MAP_REGS];
  logic [SMP_W-1:0]    recent [MAP_REGS];
  int                  slot;

  asdm_chan_if #(.T(cfg_wr_t)) cfg_ch ();
  asdm_chan_if #(.T(req_t))    req_ch ();
  asdm_chan_if #(.T(res_t))    res_ch ();

  adc_scan_deadband_mapper_top dut (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .req_ch (req_ch),
    .res_ch (res_ch)
  );

  asdm_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_data    (cfg_ch.data),
    .req_valid   (req_ch.valid),
    .req_ready   (req_ch.ready),
    .req_data    (req_ch.data),
    .res_valid   (res_ch.valid),
    .res_ready   (res_ch.ready),
    .res_data    (res_ch.data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Abort when no channel has moved anything for too long.
  always @(posedge clk) begin
    if (rst || (cfg_ch.valid && cfg_ch.ready) || (req_ch.valid && req_ch.ready) ||
        (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL adc_scan_deadband_mapper_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random back-pressure, plus one long hold on request.
  initial begin
    int held;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        for (held = 0; held < LONG_STALL; held++) @(posedge clk);
      end else if ($urandom_range(0, 99) < idle_pct) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [MAP_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cfg_wr_t'{index: idx, value: val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic load_config();
    int k;
    write_reg(REG_ENABLE, MAP_W'(cur_en));
    write_reg(REG_JITTER, MAP_W'(cur_jit));
    for (k = 0; k < MAP_REGS; k++) write_reg(REG_MAP0 + REG_IDX_W'(k), cur_map[k]);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_req(input logic rt, input logic [SMP_W-1:0] s);
    if ($urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= req_t'{req_type: rt, sample: s};
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Wait for every expected result, then let the pipeline empty of no-result work.
  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [MAP_W-1:0] rand_map();
    logic [7:0]       tgt;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    case ($urandom_range(0, 5))
      0:       tgt = MAP_NONE;
      1:       tgt = 8'd0;
      2:       tgt = 8'(VAR_COUNT_DEF - 1);
      3:       tgt = 8'(VAR_COUNT_DEF);
      4:       tgt = 8'd254;
      default: tgt = 8'($urandom_range(0, VAR_COUNT_DEF - 1));
    endcase
    case ($urandom_range(0, 3))
      0: begin
        lo = '0;
        hi = '1;
      end
      1: begin
        lo = '1;
        hi = '0;
      end
      default: begin
        lo = VAL_W'($urandom_range(0, 65535));
        hi = VAL_W'($urandom_range(0, 65535));
      end
    endcase
    return {tgt, 8'($urandom_range(0, 255)), lo, hi};
  endfunction

  // Half the time a value near the last one used in this slot, to hit the deadband.
  function automatic logic [SMP_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 1023);
      1: begin
        case ($urandom_range(0, 5))
          0: v = 0;
          1: v = 1;
          2: v = 511;
          3: v = 512;
          4: v = 1022;
          default: v = 1023;
        endcase
      end
      default: begin
        v = int'(recent[slot]) + int'($urandom_range(0, 48)) - 24;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
      end
    endcase
    recent[slot] = SMP_W'(v);
    return SMP_W'(v);
  endfunction

  task automatic run_phase(input bit long_stall, input bit mid_pause);
    int n;
    for (n = 0; n < SEQS_PER_PHASE; n++) begin
      if (long_stall && n == 40) sink_hold_req = 1'b1;
      if (mid_pause && n == SEQS_PER_PHASE / 2) begin
        req_ch.valid <= 1'b0;
        drain();
      end
      // occasional broken sequence: stray tick, or a done that gets overwritten
      case ($urandom_range(0, 9))
        0: send_req(REQ_TICK, SMP_W'($urandom_range(0, 1023)));
        1: send_req(REQ_DONE, SMP_W'($urandom_range(0, 1023)));
        default: ;
      endcase
      send_req(REQ_DONE, pick_sample());
      send_req(REQ_TICK, SMP_W'($urandom_range(0, 1023)));
      slot = (slot + 1) % MAP_REGS;
    end
    req_ch.valid <= 1'b0;
    drain();
  endtask

  initial begin
    int p;
    int k;
    rst           <= 1'b1;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    req_ch.valid  <= 1'b0;
    req_ch.data   <= '0;
    sink_hold_req  = 1'b0;
    idle_pct       = 0;
    slot           = 0;
    for (k = 0; k < MAP_REGS; k++) recent[k] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: nothing enabled, no maps.
    send_req(REQ_TICK, '0);
    send_req(REQ_DONE, 10'd1023);
    send_req(REQ_TICK, '1);
    req_ch.valid <= 1'b0;
    drain();

    // Map corners: full range up, full range down, targets at and past the
    // variable count, no target, and an offset window.
    cur_en     = '1;
    cur_jit    = '0;
    cur_map[0] = {8'd0, 8'd0, 16'h0000, 16'hFFFF};
    cur_map[1] = {8'(VAR_COUNT_DEF - 1), 8'hFF, 16'hFFFF, 16'h0000};
    cur_map[2] = {8'(VAR_COUNT_DEF), 8'd7, 16'h0000, 16'hFFFF};
    cur_map[3] = {MAP_NONE, 8'd0, 16'h0000, 16'h0000};
    cur_map[4] = {8'd254, 8'd1, 16'h1234, 16'h4321};
    cur_map[5] = {8'd5, 8'd3, 16'd1000, 16'd2000};
    load_config();
    send_req(REQ_TICK, '0);
    send_req(REQ_TICK, '0);           // ignored while the conversion runs
    send_req(REQ_DONE, 10'd0);        // same as the kept value: drop
    send_req(REQ_TICK, '0);
    for (k = 0; k < 5; k++) begin
      send_req(REQ_DONE, (k % 2 == 0) ? 10'd1023 : 10'd1);
      send_req(REQ_TICK, '0);
    end
    send_req(REQ_DONE, 10'd700);      // second done overwrites the first
    send_req(REQ_DONE, 10'd701);
    send_req(REQ_TICK, '0);
    req_ch.valid <= 1'b0;
    drain();

    // Deadband: a small step is dropped, a step at the threshold passes.
    cur_jit = 10'd10;
    load_config();
    for (k = 0; k < 4; k++) begin
      send_req(REQ_DONE, (k < 2) ? 10'd1018 : 10'd1013);
      send_req(REQ_TICK, '0);
    end
    req_ch.valid <= 1'b0;
    drain();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin
          idle_pct = 25;
          cur_en   = '1;
          cur_jit  = '0;
        end
        1: begin
          idle_pct = 40;
          cur_en   = '0;
          cur_jit  = SMP_W'($urandom_range(1, 31));
        end
        2: begin
          idle_pct = 0;
          cur_en   = '1;
          cur_jit  = '1;
        end
        3: begin
          idle_pct = 15;
          cur_en   = MAP_REGS'($urandom_range(0, 63));
          cur_jit  = SMP_W'($urandom_range(0, 63));
        end
        4: begin
          idle_pct = 30;
          cur_en   = MAP_REGS'($urandom_range(0, 63));
          cur_jit  = SMP_W'(1);
        end
        default: begin
          idle_pct = 0;
          cur_en   = '1;
          cur_jit  = SMP_W'($urandom_range(0, 15));
        end
      endcase
      for (k = 0; k < MAP_REGS; k++) cur_map[k] = rand_map();
      load_config();
      run_phase(p == 0, p == 3);
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS adc_scan_deadband_mapper_top");
    end else begin
      $display("FAIL adc_scan_deadband_mapper_top");
    end
    $finish;
  end

endmodule

>>> adc_scan_deadband_mapper_top.f
rtl/asdm_pkg.sv
rtl/asdm_chan_if.sv
rtl/asdm_scan.sv
rtl/asdm_div.sv
rtl/adc_scan_deadband_mapper_top.sv
sim/asdm_checker.sv
sim/tb.sv
